>>> src/radial_falloff_disc_generator_top_defines.svh
// Assertion macros used by the top module.
`ifndef RADIAL_FALLOFF_DISC_GENERATOR_TOP_DEFINES_SVH
`define RADIAL_FALLOFF_DISC_GENERATOR_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RFD_ASSERT_NOW(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define RFD_ASSERT_NEXT(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

>>> src/rfd_pkg.sv
package rfd_pkg;

    localparam int COORD_BITS        = 13;
    localparam int LOG_TABLE_ENTRIES = 1024;
    localparam int LOG_IDX_W         = $clog2(LOG_TABLE_ENTRIES);

    localparam int CENTER_W = 19;
    localparam int RADIUS_W = 16;
    localparam int GAMMA_W  = 24;
    localparam int COLOR_W  = 16;
    localparam int T_W      = 17;

    localparam int IN_DATA_W  = ((2 * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W = 4 * COLOR_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam int SQRT_STAGES = 8;
    localparam int DIV_STAGES  = 8;

    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DISC_RADIUS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAMMA_POWER = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_RED   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_GREEN = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_BLUE  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_ALPHA = 3'd7;

    typedef struct packed {
        logic        far;
        logic [31:0] v;
        logic [17:0] rem;
        logic [15:0] root;
    } sqrt_st_t;

    typedef struct packed {
        logic        zero;
        logic        one;
        logic [15:0] rem;
        logic [15:0] q;
    } div_st_t;

    typedef struct packed {
        logic zero;
        logic one;
    } tflag_t;

    typedef logic [15:0] log_rom_t [LOG_TABLE_ENTRIES];
    typedef logic [16:0] exp_rom_t [LOG_TABLE_ENTRIES];

    // One result bit of the digit-by-digit square root.
    function automatic sqrt_st_t sqrt_step(sqrt_st_t s);
        sqrt_st_t    o;
        logic [19:0] rem4;
        logic [19:0] trial;
        o     = s;
        rem4  = {s.rem, s.v[31:30]};
        trial = {2'b00, s.root, 2'b01};
        if (rem4 >= trial)
        begin
            o.rem  = 18'(rem4 - trial);
            o.root = {s.root[14:0], 1'b1};
        end
        else
        begin
            o.rem  = rem4[17:0];
            o.root = {s.root[14:0], 1'b0};
        end
        o.v = {s.v[29:0], 2'b00};
        return o;
    endfunction

    // One quotient bit of the restoring division by the radius.
    function automatic div_st_t div_step(div_st_t s, logic [15:0] r);
        div_st_t     o;
        logic [16:0] rem2;
        o    = s;
        rem2 = {s.rem, 1'b0};
        if (rem2 >= {1'b0, r})
        begin
            o.rem = 16'(rem2 - {1'b0, r});
            o.q   = {s.q[14:0], 1'b1};
        end
        else
        begin
            o.rem = rem2[15:0];
            o.q   = {s.q[14:0], 1'b0};
        end
        return o;
    endfunction

    function automatic logic [63:0] isqrt_const(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        logic [63:0] rem;
        res = '0;
        b   = 64'h4000_0000_0000_0000;
        rem = v;
        for (int j = 0; j < 32; j++)
        begin
            if (rem >= res + b)
            begin
                rem = rem - (res + b);
                res = (res >> 1) + b;
            end
            else
            begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // log2(1 + i/N) in Q0.16, one bit per squaring in Q.30.
    function automatic log_rom_t build_log_rom();
        log_rom_t    tab;
        logic [63:0] x;
        logic [15:0] acc;
        for (int i = 0; i < LOG_TABLE_ENTRIES; i++)
        begin
            x   = ((64'(LOG_TABLE_ENTRIES) + 64'(i)) << 30) / LOG_TABLE_ENTRIES;
            acc = '0;
            for (int b = 15; b >= 0; b--)
            begin
                x = (x * x) >> 30;
                if (x >= (64'd1 << 31))
                begin
                    x      = x >> 1;
                    acc[b] = 1'b1;
                end
            end
            tab[i] = acc;
        end
        return tab;
    endfunction

    // 2^(-f) in Q1.16 as a product of factors 2^(-2^-b).
    function automatic exp_rom_t build_exp_rom();
        exp_rom_t    tab;
        logic [63:0] fac [17];
        logic [63:0] f16;
        logic [63:0] v;
        fac[0] = 64'd1 << 29;
        for (int b = 1; b <= 16; b++)
        begin
            fac[b] = isqrt_const(fac[b-1] << 30);
        end
        for (int i = 0; i < LOG_TABLE_ENTRIES; i++)
        begin
            f16 = (64'(i) << 16) / LOG_TABLE_ENTRIES;
            v   = 64'd1 << 30;
            for (int b = 1; b <= 16; b++)
            begin
                if (f16[16-b])
                begin
                    v = (v * fac[b]) >> 30;
                end
            end
            tab[i] = 17'(v >> 14);
        end
        return tab;
    endfunction

endpackage

>>> src/rfd_pow_unit.sv
module rfd_pow_unit
    import rfd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [T_W-1:0]     in_t,
    input  logic [GAMMA_W-1:0] gamma,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [T_W-1:0]     out_p
);

    localparam int PS = 6;
    localparam log_rom_t LOG_ROM = build_log_rom();
    localparam exp_rom_t EXP_ROM = build_exp_rom();

    logic [PS-1:0] vld_reg;
    logic [PS-1:0] ld;

    logic [4:0]           s0_reg, s1_reg;
    logic [LOG_IDX_W-1:0] idx0_reg;
    tflag_t               fl0_reg, fl1_reg, fl2_reg, fl3_reg, fl4_reg;
    logic [15:0]          log1_reg;
    logic [44:0]          e2_reg;
    logic [4:0]           kk3_reg, kk4_reg;
    logic                 kill3_reg, kill4_reg;
    logic [LOG_IDX_W-1:0] xidx3_reg;
    logic [16:0]          exp4_reg;
    logic [T_W-1:0]       p5_reg;

    logic [3:0]  lead;
    logic [4:0]  shift0;
    logic [15:0] frac0;
    logic [31:0] idx_prod0;
    logic [20:0] nl2;
    logic [12:0] k3;
    logic [31:0] idx_prod3;

    always_comb
    begin
        ld[PS-1] = !vld_reg[PS-1] || out_ready;
        for (int k = PS - 2; k >= 0; k--)
        begin
            ld[k] = !vld_reg[k] || ld[k+1];
        end
    end

    assign in_ready  = ld[0];
    assign out_valid = vld_reg[PS-1];
    assign out_p     = p5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (ld[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int k = 1; k < PS; k++)
            begin
                if (ld[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // Leading one of the mantissa and the log table index.
    always_comb
    begin
        lead = '0;
        for (int j = 0; j < 16; j++)
        begin
            if (in_t[j])
            begin
                lead = 4'(j);
            end
        end
        shift0    = 5'd16 - {1'b0, lead};
        frac0     = in_t[15:0] << shift0;
        idx_prod0 = 32'(frac0) * 32'(LOG_TABLE_ENTRIES);
    end

    assign nl2       = {s1_reg, 16'b0} - 21'(log1_reg);
    assign k3        = e2_reg[44:32];
    assign idx_prod3 = 32'(e2_reg[31:16]) * 32'(LOG_TABLE_ENTRIES);

    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            s0_reg   <= shift0;
            idx0_reg <= idx_prod0[16 +: LOG_IDX_W];
            fl0_reg  <= '{zero: (in_t == '0), one: in_t[16]};
        end
        if (ld[1])
        begin
            log1_reg <= LOG_ROM[idx0_reg];
            s1_reg   <= s0_reg;
            fl1_reg  <= fl0_reg;
        end
        if (ld[2])
        begin
            e2_reg  <= 45'(gamma) * 45'(nl2);
            fl2_reg <= fl1_reg;
        end
        if (ld[3])
        begin
            kill3_reg <= (k3 > 13'd16);
            kk3_reg   <= k3[4:0];
            xidx3_reg <= idx_prod3[16 +: LOG_IDX_W];
            fl3_reg   <= fl2_reg;
        end
        if (ld[4])
        begin
            exp4_reg  <= EXP_ROM[xidx3_reg];
            kk4_reg   <= kk3_reg;
            kill4_reg <= kill3_reg;
            fl4_reg   <= fl3_reg;
        end
        if (ld[5])
        begin
            if (fl4_reg.one)
            begin
                p5_reg <= 17'h10000;
            end
            else if (fl4_reg.zero || kill4_reg)
            begin
                p5_reg <= '0;
            end
            else
            begin
                p5_reg <= exp4_reg >> kk4_reg;
            end
        end
    end

endmodule

>>> src/radial_falloff_disc_generator_top.sv
// Channel | Direction | Transaction
// s_*     | in        | one pixel coordinate: pixel_x, pixel_y
// m_*     | out       | one RGBA result: red, green, blue, alpha
// cfg_*   | in        | one register write: index and data
//
// One pixel is accepted every clock while s_tready is high; its result passes through
// 28 register stages, the first loaded at the accepting edge; most of them are
// the two-bits-per-stage square root and divider pipelines.
// Reset clears every valid bit and loads the register reset values; the tables are ROM.
// Each stage holds while the stage after it is full and stalled, so bubbles close up.
// cfg_ready is tied high, so users must write registers only with the pipeline empty.
`include "radial_falloff_disc_generator_top_defines.svh"

module radial_falloff_disc_generator_top
    import rfd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // pixel_x, pixel_y, zero pad
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // red, green, blue, alpha
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int PIX16_W = COORD_BITS + 4;
    localparam int DX_W    = ((PIX16_W > CENTER_W - 1) ? PIX16_W : CENTER_W - 1) + 2;
    localparam int MAG_W   = DX_W - 1;
    localparam int SUM_W   = 2 * MAG_W + 1;
    localparam int ST_C    = 2;
    localparam int ST_Q0   = 3;
    localparam int ST_R    = ST_Q0 + SQRT_STAGES;
    localparam int ST_V0   = ST_R + 1;
    localparam int ST_T    = ST_V0 + DIV_STAGES;
    localparam int NPRE    = ST_T + 1;

    logic signed [CENTER_W-1:0] center_x_reg, center_y_reg;
    logic [RADIUS_W-1:0]        radius_reg;
    logic [GAMMA_W-1:0]         gamma_reg;
    logic [COLOR_W-1:0]         color_reg [4];

    logic [NPRE-1:0] vld_reg;
    logic [NPRE-1:0] ld;

    logic [MAG_W-1:0]   ax_reg, ay_reg;
    logic [2*MAG_W-1:0] sqx_reg, sqy_reg;
    sqrt_st_t           sum_reg;
    sqrt_st_t           sq_reg [SQRT_STAGES];
    div_st_t            dv_reg [DIV_STAGES + 1];
    logic [T_W-1:0]     t_reg;

    logic signed [DX_W-1:0] dx_a, dy_a;
    logic [SUM_W-1:0]       sum_c;
    logic [15:0]            d_r;
    logic [GAMMA_W-1:0]     gamma_eff;

    logic           pow_in_ready;
    logic           pow_out_valid;
    logic           pow_out_ready;
    logic [T_W-1:0] pow_p;

    logic                  out_vld_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [OUT_DATA_W-1:0] out_data_next;

    function automatic logic [COLOR_W-1:0] scale_sat(logic [T_W-1:0] p,
                                                      logic [COLOR_W-1:0] c);
        logic [32:0] prod;
        prod = 33'(p) * 33'(c);
        return prod[32] ? '1 : prod[31:16];
    endfunction

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            radius_reg   <= 16'd1024;
            gamma_reg    <= 24'd65536;
            for (int c = 0; c < 4; c++)
            begin
                color_reg[c] <= 16'd16384;
            end
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_CENTER_X:    center_x_reg <= cfg_data[CENTER_W-1:0];
                REG_CENTER_Y:    center_y_reg <= cfg_data[CENTER_W-1:0];
                REG_DISC_RADIUS: radius_reg   <= cfg_data[RADIUS_W-1:0];
                REG_GAMMA_POWER: gamma_reg    <= cfg_data[GAMMA_W-1:0];
                REG_COLOR_RED:   color_reg[0] <= cfg_data[COLOR_W-1:0];
                REG_COLOR_GREEN: color_reg[1] <= cfg_data[COLOR_W-1:0];
                REG_COLOR_BLUE:  color_reg[2] <= cfg_data[COLOR_W-1:0];
                REG_COLOR_ALPHA: color_reg[3] <= cfg_data[COLOR_W-1:0];
                default:         ;
            endcase
        end
    end

    // Zero gamma behaves as the smallest step.
    assign gamma_eff = (gamma_reg == '0) ? GAMMA_W'(1) : gamma_reg;

    always_comb
    begin
        ld[NPRE-1] = !vld_reg[NPRE-1] || pow_in_ready;
        for (int k = NPRE - 2; k >= 0; k--)
        begin
            ld[k] = !vld_reg[k] || ld[k+1];
        end
    end

    assign s_tready = ld[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (ld[0])
            begin
                vld_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < NPRE; k++)
            begin
                if (ld[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    assign dx_a = $signed({{(DX_W - PIX16_W){1'b0}}, s_tdata[COORD_BITS-1:0], 4'b0000})
                - $signed({{(DX_W - CENTER_W){center_x_reg[CENTER_W-1]}}, center_x_reg});
    assign dy_a = $signed({{(DX_W - PIX16_W){1'b0}},
                           s_tdata[2*COORD_BITS-1:COORD_BITS], 4'b0000})
                - $signed({{(DX_W - CENTER_W){center_y_reg[CENTER_W-1]}}, center_y_reg});
    assign sum_c = SUM_W'(sqx_reg) + SUM_W'(sqy_reg);
    assign d_r   = sq_reg[SQRT_STAGES-1].root;

    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            ax_reg <= dx_a[DX_W-1] ? MAG_W'(-dx_a) : MAG_W'(dx_a);
            ay_reg <= dy_a[DX_W-1] ? MAG_W'(-dy_a) : MAG_W'(dy_a);
        end
        if (ld[1])
        begin
            sqx_reg <= (2*MAG_W)'(ax_reg) * (2*MAG_W)'(ax_reg);
            sqy_reg <= (2*MAG_W)'(ay_reg) * (2*MAG_W)'(ay_reg);
        end
        // A sum of 2^32 or more gives a distance beyond any radius.
        if (ld[ST_C])
        begin
            sum_reg <= '{far: |sum_c[SUM_W-1:32], v: sum_c[31:0], rem: '0, root: '0};
        end
        if (ld[ST_Q0])
        begin
            sq_reg[0] <= sqrt_step(sqrt_step(sum_reg));
        end
        for (int i = 1; i < SQRT_STAGES; i++)
        begin
            if (ld[ST_Q0 + i])
            begin
                sq_reg[i] <= sqrt_step(sqrt_step(sq_reg[i-1]));
            end
        end
        if (ld[ST_R])
        begin
            dv_reg[0].zero <= sq_reg[SQRT_STAGES-1].far || (radius_reg == '0)
                              || (d_r >= radius_reg);
            dv_reg[0].one  <= (d_r == '0) && (radius_reg != '0)
                              && !sq_reg[SQRT_STAGES-1].far;
            dv_reg[0].rem  <= radius_reg - d_r;
            dv_reg[0].q    <= '0;
        end
        for (int i = 0; i < DIV_STAGES; i++)
        begin
            if (ld[ST_V0 + i])
            begin
                dv_reg[i+1] <= div_step(div_step(dv_reg[i], radius_reg), radius_reg);
            end
        end
        if (ld[ST_T])
        begin
            if (dv_reg[DIV_STAGES].zero)
            begin
                t_reg <= '0;
            end
            else if (dv_reg[DIV_STAGES].one)
            begin
                t_reg <= 17'h10000;
            end
            else
            begin
                t_reg <= {1'b0, dv_reg[DIV_STAGES].q};
            end
        end
    end

    rfd_pow_unit u_pow (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vld_reg[NPRE-1]),
        .in_ready  (pow_in_ready),
        .in_t      (t_reg),
        .gamma     (gamma_eff),
        .out_valid (pow_out_valid),
        .out_ready (pow_out_ready),
        .out_p     (pow_p)
    );

    assign pow_out_ready = !out_vld_reg || m_tready;

    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            out_data_next[c*COLOR_W +: COLOR_W] = scale_sat(pow_p, color_reg[c]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (pow_out_ready)
        begin
            out_vld_reg <= pow_out_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pow_out_ready)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

    `RFD_ASSERT_NOW(a_empty_front_ready, !vld_reg[0], s_tready,
                    "input not ready with an empty first stage")
    `RFD_ASSERT_NEXT(a_accept_fills, s_tvalid && s_tready, vld_reg[0],
                     "accepted transaction did not enter the pipeline")
    `RFD_ASSERT_NEXT(a_t_hold, vld_reg[NPRE-1] && !pow_in_ready,
                     vld_reg[NPRE-1] && $stable(t_reg),
                     "stalled falloff value changed")

endmodule

>>> tb/radial_falloff_disc_generator_top_tb.sv
`timescale 1ns / 1ps

module radial_falloff_disc_generator_top_tb;
    import rfd_pkg::*;

    localparam int LATENCY     = 28;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [15:0] alpha;
        logic [15:0] blue;
        logic [15:0] green;
        logic [15:0] red;
    } rgba_t;

    typedef struct {
        logic [12:0] px;
        logic [12:0] py;
        bit          fixed;   // expected value typed in below
        rgba_t       want;
    } pixel_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    radial_falloff_disc_generator_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predictor copy of the registers.
    logic signed [18:0] ctr_x;
    logic signed [18:0] ctr_y;
    logic [15:0]        radius;
    logic [23:0]        gamma;
    logic [15:0]        tint [4];

    logic [15:0] log2_rom [LOG_TABLE_ENTRIES];
    logic [16:0] exp2_rom [LOG_TABLE_ENTRIES];

    rgba_t pending_rgba [$];
    int    fail_count;
    int    cycles;
    bit    quiet_phase;   // no random idling while set
    bit    hold_sink;     // long receiver hold-off request

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic [63:0] root64(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = '0;
        b   = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    task automatic fill_roms();
        logic [63:0] fac [17];
        logic [63:0] x;
        logic [63:0] f16;
        logic [63:0] v;
        logic [15:0] acc;
        fac[0] = 64'd1 << 29;
        for (int b = 1; b <= 16; b++)
            fac[b] = root64(fac[b-1] << 30);
        for (int i = 0; i < LOG_TABLE_ENTRIES; i++)
        begin
            x   = ((64'(LOG_TABLE_ENTRIES) + 64'(i)) << 30) / LOG_TABLE_ENTRIES;
            acc = '0;
            for (int b = 15; b >= 0; b--)
            begin
                x = (x * x) >> 30;
                if (x >= (64'd1 << 31))
                begin
                    x      = x >> 1;
                    acc[b] = 1'b1;
                end
            end
            log2_rom[i] = acc;
            f16 = (64'(i) << 16) / LOG_TABLE_ENTRIES;
            v   = 64'd1 << 30;
            for (int b = 1; b <= 16; b++)
                if (f16[16-b])
                    v = (v * fac[b]) >> 30;
            exp2_rom[i] = 17'(v >> 14);
        end
    endtask

    function automatic logic [63:0] falloff_power(logic [63:0] t, logic [63:0] g);
        int          lead;
        logic [63:0] f;
        logic [63:0] nl;
        logic [63:0] e;
        logic [63:0] k;
        if (t == 0)
            return 0;
        if (t >= 65536)
            return 65536;
        lead = 15;
        while (t[lead] == 1'b0)
            lead--;
        f  = (t << (16 - lead)) & 64'hFFFF;
        nl = 64'(16 - lead) * 65536 - log2_rom[(f * LOG_TABLE_ENTRIES) >> 16];
        e  = (g * nl) >> 16;
        k  = e >> 16;
        if (k > 16)
            return 0;
        return 64'(exp2_rom[((e & 64'hFFFF) * LOG_TABLE_ENTRIES) >> 16]) >> k;
    endfunction

    function automatic rgba_t shade_pixel(logic [12:0] px, logic [12:0] py);
        longint      dx;
        longint      dy;
        logic [63:0] d;
        logic [63:0] t;
        logic [63:0] g;
        logic [63:0] pw;
        logic [63:0] v;
        logic [15:0] ch [4];
        dx = longint'(px) * 16 - longint'(ctr_x);
        dy = longint'(py) * 16 - longint'(ctr_y);
        d  = root64(64'(dx * dx + dy * dy));
        t  = (radius != 0 && d < radius) ? ((64'(radius) - d) << 16) / radius : 0;
        g  = (gamma != 0) ? 64'(gamma) : 64'd1;
        pw = falloff_power(t, g);
        for (int c = 0; c < 4; c++)
        begin
            v     = (pw * tint[c]) >> 16;
            ch[c] = (v > 65535) ? 16'hFFFF : v[15:0];
        end
        return '{alpha: ch[3], blue: ch[2], green: ch[1], red: ch[0]};
    endfunction

    // One write, then the channel goes idle.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_CENTER_X:    ctr_x     = val[18:0];
            REG_CENTER_Y:    ctr_y     = val[18:0];
            REG_DISC_RADIUS: radius    = val[15:0];
            REG_GAMMA_POWER: gamma     = val;
            REG_COLOR_RED:   tint[0]   = val[15:0];
            REG_COLOR_GREEN: tint[1]   = val[15:0];
            REG_COLOR_BLUE:  tint[2]   = val[15:0];
            REG_COLOR_ALPHA: tint[3]   = val[15:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        while (pending_rgba.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    // Offers one pixel; random gaps precede it unless the quiet phase is on.
    task automatic send_pixel(logic [12:0] px, logic [12:0] py, bit fixed, rgba_t want);
        if (!quiet_phase)
            while ($urandom_range(99) < 15)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_DATA_W'({py, px});
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_rgba.push_back(fixed ? want : shade_pixel(px, py));
    endtask

    task automatic send_idle();
        s_tvalid <= 1'b0;
    endtask

    // Receiver side.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_rgba.size() == 0)
            begin
                $display("%0t: result with nothing expected, actual %h", $time, m_tdata);
                fail_count <= fail_count + 1;
            end
            else
            begin
                rgba_t want;
                rgba_t got;
                want = pending_rgba.pop_front();
                got  = m_tdata;
                if (got.red !== want.red || got.green !== want.green ||
                    got.blue !== want.blue || got.alpha !== want.alpha)
                begin
                    $display("%0t: mismatch expected %h actual %h", $time, want, got);
                    fail_count <= fail_count + 1;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (hold_sink)
        begin
            m_tready <= 1'b0;
            repeat (300) @(posedge clk);
            m_tready <= 1'b1;
            @(posedge clk);
        end
        else
            m_tready <= quiet_phase || ($urandom_range(99) >= 15);
    end

    pixel_row_t directed [] = '{
        '{13'd0,    13'd0,    1'b1, '{16'd16384, 16'd16384, 16'd16384, 16'd16384}},
        '{13'd8191, 13'd8191, 1'b1, '{16'd0, 16'd0, 16'd0, 16'd0}},
        '{13'd8191, 13'd0,    1'b1, '{16'd0, 16'd0, 16'd0, 16'd0}},
        '{13'd0,    13'd8191, 1'b1, '{16'd0, 16'd0, 16'd0, 16'd0}},
        '{13'd1,    13'd0,    1'b0, '0},
        '{13'd0,    13'd1,    1'b0, '0},
        '{13'd3,    13'd4,    1'b0, '0},
        '{13'd40,   13'd30,   1'b0, '0},
        '{13'd63,   13'd0,    1'b0, '0},
        '{13'd64,   13'd0,    1'b1, '{16'd0, 16'd0, 16'd0, 16'd0}},
        '{13'd45,   13'd45,   1'b0, '0},
        '{13'd4096, 13'd2730, 1'b0, '0},
        '{13'd5461, 13'd1365, 1'b0, '0}
    };

    function automatic logic [23:0] pick_reg(int idx);
        case (idx)
            0, 1: return 24'($urandom_range(2) == 0 ? 24'h40000 + $urandom_range(1) :
                                                     $urandom_range(131071 + 16 * 2100));
            2: return 24'($urandom_range(3) == 0 ? 65535 : $urandom_range(1, 4000));
            3: return 24'($urandom_range(4) == 0 ? $urandom_range(16777215) :
                                                  $urandom_range(1, 600000));
            default: return 24'($urandom_range(65535));
        endcase
    endfunction

    initial
    begin
        rgba_t none;
        none        = '0;
        clk         = 1'b0;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        m_tready    = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        fail_count  = 0;
        cycles      = 0;
        quiet_phase = 1'b0;
        hold_sink   = 1'b0;
        ctr_x  = 0;
        ctr_y  = 0;
        radius = 16'd1024;
        gamma  = 24'd65536;
        for (int c = 0; c < 4; c++)
            tint[c] = 16'd16384;
        fill_roms();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_pixel(directed[i].px, directed[i].py, directed[i].fixed, directed[i].want);
        send_idle();
        drain();

        // Zero radius, zero gamma, extreme colors and the far corner center.
        write_reg(REG_DISC_RADIUS, 24'd0);
        send_pixel(13'd0, 13'd0, 1'b1, none);
        send_idle();
        drain();
        write_reg(REG_DISC_RADIUS, 24'd65535);
        write_reg(REG_GAMMA_POWER, 24'd0);
        write_reg(REG_COLOR_RED, 24'hFFFF);
        write_reg(REG_COLOR_GREEN, 24'd0);
        write_reg(REG_COLOR_BLUE, 24'd1);
        write_reg(REG_COLOR_ALPHA, 24'h8000);
        send_pixel(13'd0, 13'd0, 1'b1, '{16'h8000, 16'd1, 16'd0, 16'hFFFF});
        send_pixel(13'd100, 13'd200, 1'b0, none);
        send_idle();
        drain();
        write_reg(REG_GAMMA_POWER, 24'hFFFFFF);
        write_reg(REG_CENTER_X, 24'h3FFFF);
        write_reg(REG_CENTER_Y, 24'h40000);
        send_pixel(13'd8191, 13'd0, 1'b0, none);
        send_pixel(13'd8000, 13'd10, 1'b0, none);
        send_idle();
        drain();

        for (int phase = 0; phase < 16; phase++)
        begin
            for (int r = 0; r < 8; r++)
                write_reg(CFG_IDX_W'(r), pick_reg(r));
            quiet_phase = (phase == 3);
            if (phase == 5)
            begin
                hold_sink <= 1'b1;
                @(posedge clk);
                hold_sink <= 1'b0;
            end
            for (int n = 0; n < 120; n++)
            begin
                logic [12:0] px;
                logic [12:0] py;
                // Mostly near the disc so that the falloff is exercised.
                if ($urandom_range(9) < 7)
                begin
                    px = 13'((ctr_x >>> 4) + $signed($urandom_range(2 * 300) - 300));
                    py = 13'((ctr_y >>> 4) + $signed($urandom_range(2 * 300) - 300));
                end
                else
                begin
                    px = 13'($urandom_range(8191));
                    py = 13'($urandom_range(8191));
                end
                send_pixel(px, py, 1'b0, none);
            end
            send_idle();
            quiet_phase = 1'b0;
            drain();
        end

        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
